>>> rtl/core/ipc_pkg.sv
// Shared types and constants for the infix-to-postfix converter.
// No dependencies; used by the stack cell and the top level.
package ipc_pkg;

  localparam int SYM_W  = 8;
  localparam int KIND_W = 2;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_SYMBOL = 2'd0;
  localparam logic [KIND_W-1:0] KIND_OK     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERROR  = 2'd2;

  localparam logic [SYM_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [SYM_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [SYM_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [SYM_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [SYM_W-1:0] CH_CARET  = 8'h5E;
  localparam logic [SYM_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [SYM_W-1:0] CH_RPAREN = 8'h29;

  // operation applied to every cell of the stack at the same time
  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
  } stk_op_t;

  // precedence: unknown 0, + - 1, * / 2, ^ 3
  function automatic logic [1:0] prec(input logic [SYM_W-1:0] c);
    logic [1:0] p;
    p = 2'd0;
    if (c == CH_PLUS || c == CH_MINUS) p = 2'd1;
    else if (c == CH_STAR || c == CH_SLASH) p = 2'd2;
    else if (c == CH_CARET) p = 2'd3;
    return p;
  endfunction

  function automatic logic is_operand(input logic [SYM_W-1:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
           (c >= 8'h30 && c <= 8'h39);
  endfunction

endpackage

>>> rtl/core/ipc_if.sv
// Valid/ready channel interfaces for the converter's input and result items.
// Depends on ipc_pkg for field widths.
interface ipc_sym_if;
  logic                        valid;
  logic                        ready;
  logic [ipc_pkg::SYM_W-1:0]   symbol;
  logic                        end_of_expression;

  modport source (output valid, symbol, end_of_expression, input ready);
  modport sink   (input valid, symbol, end_of_expression, output ready);
endinterface

interface ipc_res_if;
  logic                        valid;
  logic                        ready;
  logic [ipc_pkg::SYM_W-1:0]   out_symbol;
  logic [ipc_pkg::KIND_W-1:0]  kind;
  logic                        last;

  modport source (output valid, out_symbol, kind, last, input ready);
  modport sink   (input valid, out_symbol, kind, last, output ready);
endinterface

>>> rtl/core/infix_to_postfix_converter.sv
// Channel  Dir  Fields                               Handshake
// din      in   symbol[7:0], end_of_expression       valid/ready
// dout     out  out_symbol[7:0], kind[1:0], last     valid/ready
//
// An operand or '(' is handled as it is taken. An operator or ')' is taken,
// then pops stacked entries one by one through the cell row, then finishes.
// An end item on an empty stack or after an error is handled as it is taken;
// else it is taken, each stacked entry is popped in turn, then the end result.
// Synchronous reset empties the stack and clears the error flag.
// A stalled result register holds the pop loop; din is taken only when idle.
// Depends on ipc_pkg, ipc_if and ipc_stack_cell.
module infix_to_postfix_converter #(
  parameter int STACK_DEPTH = 32
) (
  input  logic          clk,
  input  logic          rst,
  ipc_sym_if.sink       din,
  ipc_res_if.source     dout
);

  typedef enum logic [1:0] {S_IDLE, S_FLUSH, S_CLOSE, S_OPER} state_t;

  state_t                     state, state_next;
  logic                       err, err_next;
  logic [ipc_pkg::SYM_W-1:0]  cur_sym, cur_sym_next;

  logic                       o_valid;
  logic [ipc_pkg::SYM_W-1:0]  o_sym;
  logic [ipc_pkg::KIND_W-1:0] o_kind;
  logic                       o_last;

  logic                       emit;
  logic [ipc_pkg::SYM_W-1:0]  e_sym;
  logic [ipc_pkg::KIND_W-1:0] e_kind;
  logic                       e_last;

  ipc_pkg::stk_op_t           op;
  logic [ipc_pkg::SYM_W-1:0]  push_data;
  logic [ipc_pkg::SYM_W-1:0]  cell_data [STACK_DEPTH];
  logic [STACK_DEPTH-1:0]     cell_vld;

  logic slot_free, accept, empty, full;
  logic [ipc_pkg::SYM_W-1:0] top;

  genvar gi;
  generate
    for (gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
      logic [ipc_pkg::SYM_W-1:0] up_d, dn_d;
      logic                      up_v, dn_v;
      if (gi == 0) begin : g_head
        assign up_d = push_data;
        assign up_v = 1'b1;
      end else begin : g_mid
        assign up_d = cell_data[gi-1];
        assign up_v = cell_vld[gi-1];
      end
      if (gi == STACK_DEPTH-1) begin : g_tail
        assign dn_d = '0;
        assign dn_v = 1'b0;
      end else begin : g_body
        assign dn_d = cell_data[gi+1];
        assign dn_v = cell_vld[gi+1];
      end
      ipc_stack_cell u_cell (
        .clk     (clk),
        .rst     (rst),
        .op      (op),
        .up_data (up_d),
        .up_vld  (up_v),
        .dn_data (dn_d),
        .dn_vld  (dn_v),
        .data    (cell_data[gi]),
        .vld     (cell_vld[gi])
      );
    end
  endgenerate

  assign top       = cell_data[0];
  assign empty     = !cell_vld[0];
  assign full      = cell_vld[STACK_DEPTH-1];
  assign slot_free = !o_valid || dout.ready;
  assign din.ready = (state == S_IDLE) && slot_free;
  assign accept    = din.valid && din.ready;

  assign dout.valid      = o_valid;
  assign dout.out_symbol = o_sym;
  assign dout.kind       = o_kind;
  assign dout.last       = o_last;

  always_comb begin
    state_next   = state;
    err_next     = err;
    cur_sym_next = cur_sym;
    op           = '0;
    push_data    = cur_sym;
    emit         = 1'b0;
    e_sym        = top;
    e_kind       = ipc_pkg::KIND_SYMBOL;
    e_last       = 1'b0;
    unique case (state)
      S_IDLE: begin
        push_data = din.symbol;
        if (accept) begin
          priority if (din.end_of_expression) begin
            if (err) begin
              emit     = 1'b1;
              e_sym    = '0;
              e_kind   = ipc_pkg::KIND_ERROR;
              e_last   = 1'b1;
              op.clear = 1'b1;
              err_next = 1'b0;
            end else if (empty) begin
              emit   = 1'b1;
              e_sym  = '0;
              e_kind = ipc_pkg::KIND_OK;
              e_last = 1'b1;
            end else begin
              state_next = S_FLUSH;
            end
          end else if (err) begin
            // dropped until the end item
          end else if (ipc_pkg::is_operand(din.symbol)) begin
            emit  = 1'b1;
            e_sym = din.symbol;
          end else if (din.symbol == ipc_pkg::CH_LPAREN) begin
            if (full) begin
              err_next = 1'b1;
              op.clear = 1'b1;
            end else begin
              op.push = 1'b1;
            end
          end else if (din.symbol == ipc_pkg::CH_RPAREN) begin
            state_next = S_CLOSE;
          end else begin
            cur_sym_next = din.symbol;
            state_next   = S_OPER;
          end
        end
      end
      S_FLUSH: begin
        if (slot_free) begin
          emit = 1'b1;
          if (!empty) begin
            op.pop = 1'b1;
          end else begin
            e_sym      = '0;
            e_kind     = ipc_pkg::KIND_OK;
            e_last     = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      S_CLOSE: begin
        priority if (empty) begin
          err_next   = 1'b1;
          op.clear   = 1'b1;
          state_next = S_IDLE;
        end else if (top == ipc_pkg::CH_LPAREN) begin
          op.pop     = 1'b1;
          state_next = S_IDLE;
        end else if (slot_free) begin
          emit   = 1'b1;
          op.pop = 1'b1;
        end else begin
          // wait for the result slot
        end
      end
      S_OPER: begin
        if (!empty && (ipc_pkg::prec(cur_sym) <= ipc_pkg::prec(top))) begin
          if (slot_free) begin
            emit   = 1'b1;
            op.pop = 1'b1;
          end
        end else begin
          if (full) begin
            err_next = 1'b1;
            op.clear = 1'b1;
          end else begin
            op.push = 1'b1;
          end
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      err     <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      state   <= state_next;
      err     <= err_next;
      if (emit) begin
        o_valid <= 1'b1;
      end else if (dout.ready) begin
        o_valid <= 1'b0;
      end
    end
    cur_sym <= cur_sym_next;
    if (emit) begin
      o_sym  <= e_sym;
      o_kind <= e_kind;
      o_last <= e_last;
    end
  end

  // stack entries stay packed toward the top cell
  a_stack_packed: assert property (@(posedge clk) disable iff (rst)
    ((cell_vld >> 1) & ~cell_vld) == '0)
    else $error("stack cell valid bits not contiguous");

  // while an error is pending the stack holds nothing
  a_err_empty: assert property (@(posedge clk) disable iff (rst)
    err |-> empty)
    else $error("stack not empty after error");

  // the closing result of an expression never carries a symbol kind
  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    (o_valid && o_last) |-> (o_kind != ipc_pkg::KIND_SYMBOL && o_sym == '0))
    else $error("end result carries a symbol");

  // no new result is loaded over one that is still stalled
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (o_valid && !dout.ready) |-> !emit)
    else $error("result register overwritten while stalled");

endmodule

>>> rtl/core/ipc_stack_cell.sv
// One entry of the shifting operator stack.
// Depends on ipc_pkg (stk_op_t). Push takes the upper neighbor, pop the lower.
module ipc_stack_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  ipc_pkg::stk_op_t          op,
  input  logic [ipc_pkg::SYM_W-1:0] up_data,
  input  logic                      up_vld,
  input  logic [ipc_pkg::SYM_W-1:0] dn_data,
  input  logic                      dn_vld,
  output logic [ipc_pkg::SYM_W-1:0] data,
  output logic                      vld
);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (op.clear) begin
      vld <= 1'b0;
    end else if (op.push) begin
      vld <= up_vld;
    end else if (op.pop) begin
      vld <= dn_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (op.push) begin
      data <= up_data;
    end else if (op.pop) begin
      data <= dn_data;
    end
  end

endmodule

>>> tb/postfix_sb_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the infix-to-postfix converter: an operator-stack predictor
// and the queue of postfix results it expects. Depends on ipc_pkg.
package postfix_sb_pkg;

  localparam int NEST_DEPTH = 32;

  typedef struct packed {
    logic [ipc_pkg::SYM_W-1:0]  sym;
    logic [ipc_pkg::KIND_W-1:0] kind;
    logic                       last;
  } postfix_res_t;

  class postfix_scoreboard;
    postfix_res_t              pending[$];
    logic [ipc_pkg::SYM_W-1:0] op_stack [NEST_DEPTH];
    int unsigned               depth_used;
    bit                        err_flag;
    int unsigned               n_fail;

    function new();
      depth_used = 0;
      err_flag   = 1'b0;
      n_fail     = 0;
    endfunction

    static function int op_rank(logic [ipc_pkg::SYM_W-1:0] c);
      if (c == ipc_pkg::CH_PLUS || c == ipc_pkg::CH_MINUS) return 1;
      if (c == ipc_pkg::CH_STAR || c == ipc_pkg::CH_SLASH) return 2;
      if (c == ipc_pkg::CH_CARET) return 3;
      return -1;
    endfunction

    static function bit is_alnum(logic [ipc_pkg::SYM_W-1:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
             (c >= "0" && c <= "9");
    endfunction

    function void add_result(logic [ipc_pkg::SYM_W-1:0] s,
                             logic [ipc_pkg::KIND_W-1:0] k, logic l);
      postfix_res_t r;
      r.sym  = s;
      r.kind = k;
      r.last = l;
      pending.push_back(r);
    endfunction

    function void pop_emit();
      depth_used--;
      add_result(op_stack[depth_used], ipc_pkg::KIND_SYMBOL, 1'b0);
    endfunction

    function void flag_error();
      err_flag   = 1'b1;
      depth_used = 0;
    endfunction

    function void push_entry(logic [ipc_pkg::SYM_W-1:0] c);
      if (depth_used >= NEST_DEPTH) begin
        flag_error();
      end else begin
        op_stack[depth_used] = c;
        depth_used++;
      end
    endfunction

    // Returns 0 when the item is dropped (symbol after an error).
    function bit note_input(logic [ipc_pkg::SYM_W-1:0] s, logic eoe);
      int r;
      if (eoe) begin
        if (!err_flag) begin
          while (depth_used > 0) pop_emit();
          add_result('0, ipc_pkg::KIND_OK, 1'b1);
        end else begin
          add_result('0, ipc_pkg::KIND_ERROR, 1'b1);
        end
        depth_used = 0;
        err_flag   = 1'b0;
        return 1'b1;
      end
      if (err_flag) return 1'b0;
      if (is_alnum(s)) begin
        add_result(s, ipc_pkg::KIND_SYMBOL, 1'b0);
      end else if (s == ipc_pkg::CH_LPAREN) begin
        push_entry(s);
      end else if (s == ipc_pkg::CH_RPAREN) begin
        while (depth_used > 0 && op_stack[depth_used-1] != ipc_pkg::CH_LPAREN)
          pop_emit();
        if (depth_used == 0) flag_error();
        else depth_used--;
      end else begin
        r = op_rank(s);
        // unknown operators rank -1, so they pop '(' as well
        while (depth_used > 0 && r <= op_rank(op_stack[depth_used-1])) pop_emit();
        push_entry(s);
      end
      return 1'b1;
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      n_fail++;
    endtask

    task check_result(postfix_res_t got);
      postfix_res_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result sym=%h kind=%0d last=%0d",
                         got.sym, got.kind, got.last));
        return;
      end
      want = pending.pop_front();
      if (got.sym !== want.sym)
        report($sformatf("out_symbol got %h want %h", got.sym, want.sym));
      if (got.kind !== want.kind)
        report($sformatf("kind got %0d want %0d", got.kind, want.kind));
      if (got.last !== want.last)
        report($sformatf("last got %0d want %0d", got.last, want.last));
    endtask
  endclass

endpackage

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// Top-level testbench for infix_to_postfix_converter: drives character items,
// checks postfix results. Depends on ipc_pkg, ipc_if and postfix_sb_pkg.
module tb_top;

  logic clk = 1'b0;
  logic rst;

  ipc_sym_if din_if ();
  ipc_res_if dout_if ();

  infix_to_postfix_converter #(.STACK_DEPTH(postfix_sb_pkg::NEST_DEPTH)) u_dut (
    .clk  (clk),
    .rst  (rst),
    .din  (din_if),
    .dout (dout_if)
  );

  postfix_sb_pkg::postfix_scoreboard sb = new();

  int unsigned src_idle_pct  = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned items_taken   = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // result side: check accepted items, then pick next ready
  always @(posedge clk) begin
    postfix_sb_pkg::postfix_res_t got;
    if (!rst && dout_if.valid && dout_if.ready) begin
      got.sym  = dout_if.out_symbol;
      got.kind = dout_if.kind;
      got.last = dout_if.last;
      sb.check_result(got);
    end
    dout_if.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  task automatic send_item(input logic [ipc_pkg::SYM_W-1:0] s, input logic eoe);
    if ($urandom_range(99) < src_idle_pct) begin
      din_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    din_if.valid             <= 1'b1;
    din_if.symbol            <= s;
    din_if.end_of_expression <= eoe;
    @(posedge clk);
    while (!din_if.ready) @(posedge clk);
    void'(sb.note_input(s, eoe));
    items_taken++;
  endtask

  // end item carries a junk symbol so the ignored field still toggles
  task automatic send_end();
    send_item(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
    send_end();
  endtask

  function automatic logic [ipc_pkg::SYM_W-1:0] pick_operand();
    int unsigned n;
    n = $urandom_range(61);
    if (n < 26) return 8'("A" + n);
    if (n < 52) return 8'("a" + n - 26);
    return 8'("0" + n - 52);
  endfunction

  function automatic logic [ipc_pkg::SYM_W-1:0] pick_operator();
    case ($urandom_range(4))
      0: return ipc_pkg::CH_PLUS;
      1: return ipc_pkg::CH_MINUS;
      2: return ipc_pkg::CH_STAR;
      3: return ipc_pkg::CH_SLASH;
      default: return ipc_pkg::CH_CARET;
    endcase
  endfunction

  // n items: opening parens, or with mix also operators that stack above them
  task automatic send_nest(input int n, input bit mix);
    for (int i = 0; i < n; i++) begin
      if (mix && $urandom_range(1)) send_item(pick_operator(), 1'b0);
      else send_item(ipc_pkg::CH_LPAREN, 1'b0);
    end
    send_end();
  endtask

  task automatic send_expression();
    int unsigned mode, len, depth;
    bit want_operand;
    logic [ipc_pkg::SYM_W-1:0] c;
    mode = $urandom_range(99);
    if (mode < 5) begin
      send_nest($urandom_range(28, 34), 1'b1);
    end else if (mode < 82) begin
      len = $urandom_range(1, 8);
      depth = 0;
      want_operand = 1'b1;
      while (len > 0 || want_operand) begin
        if (want_operand) begin
          if ($urandom_range(3) == 0 && depth < 6) begin
            send_item(ipc_pkg::CH_LPAREN, 1'b0);
            depth++;
          end else begin
            send_item(pick_operand(), 1'b0);
            want_operand = 1'b0;
            if (len > 0) len--;
          end
        end else if (depth > 0 && $urandom_range(2) == 0) begin
          send_item(ipc_pkg::CH_RPAREN, 1'b0);
          depth--;
        end else if (len > 0) begin
          send_item(pick_operator(), 1'b0);
          want_operand = 1'b1;
        end else begin
          break;
        end
      end
      // usually close what was opened; otherwise leave '(' for the flush
      if ($urandom_range(4) != 0)
        while (depth > 0) begin
          send_item(ipc_pkg::CH_RPAREN, 1'b0);
          depth--;
        end
      send_end();
    end else begin
      len = $urandom_range(1, 10);
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(5))
          0: c = ipc_pkg::CH_LPAREN;
          1: c = ipc_pkg::CH_RPAREN;
          2: c = pick_operator();
          3: c = pick_operand();
          default: c = 8'($urandom_range(255));
        endcase
        send_item(c, 1'b0);
      end
      send_end();
    end
  endtask

  task automatic hold_until_drained();
    din_if.valid <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0);
  endtask

  initial begin
    int unsigned base;
    rst                      <= 1'b1;
    din_if.valid             <= 1'b0;
    din_if.symbol            <= '0;
    din_if.end_of_expression <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: precedence, left-assoc '^', unmatched ')', dropped symbols,
    // unknown operators popping '(', leftover '(' flushed at the end
    send_text("a+b*c");
    send_text("(A-9)^z^0");
    send_text(")q");
    send_item(ipc_pkg::CH_LPAREN, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(ipc_pkg::CH_LPAREN, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'hFF, 1'b1);
    send_text("a+(");

    // deepest flush, then push onto a full stack
    send_nest(postfix_sb_pkg::NEST_DEPTH, 1'b0);
    send_nest(postfix_sb_pkg::NEST_DEPTH + 1, 1'b0);
    hold_until_drained();

    base = items_taken;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 86; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 86; end
        default: begin src_idle_pct = 21; sink_stall_pct = 21; end
      endcase
      while (items_taken < base + 27 * (ph + 1)) send_expression();
      hold_until_drained();
    end

    src_idle_pct   = 0;
    sink_stall_pct = 0;
    repeat (48) @(posedge clk);
    if (sb.n_fail == 0 && sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #4800000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
